>>> design/text_integer_parser_assert.svh
// Assertion macros shared by the text integer parser modules.
// Expects clk and rst_n (synchronous, active low) in the including module.
`ifndef TEXT_INTEGER_PARSER_ASSERT_SVH
`define TEXT_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TIP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tip assertion failed");

// Next-cycle implication, checked outside reset.
`define TIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tip assertion failed");

`endif

>>> design/tip_pkg.sv
// Shared types and constants for the text integer parser.
// No dependencies.
package tip_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  // Decimal limits checked at the tenth digit
  localparam logic [31:0] DEC_LIM_U  = 32'd429496729;
  localparam logic [31:0] DEC_LIM_S  = 32'd214748364;
  localparam logic [3:0]  LAST_U     = 4'd5;
  localparam logic [3:0]  LAST_S_POS = 4'd7;
  localparam logic [3:0]  LAST_S_NEG = 4'd8;

  localparam logic [3:0] DEC_MAX_DIGITS = 4'd10;
  localparam logic [3:0] DEC_LAST_POS   = 4'd9;
  localparam logic [3:0] HEX_MAX_DIGITS = 4'd8;

  // Classified character, front to back
  typedef struct packed {
    logic       is_end;
    logic       is_zero;
    logic       is_dec;
    logic       is_hex;
    logic       is_minus;
    logic       is_x;
    logic [3:0] digit;
    logic       want_signed;
  } tip_tok_t;

  typedef enum logic [5:0] {
    PH_START     = 6'b000001,
    PH_ZERO      = 6'b000010,
    PH_HEX_FIRST = 6'b000100,
    PH_HEX       = 6'b001000,
    PH_DEC       = 6'b010000,
    PH_FAIL      = 6'b100000
  } tip_phase_t;

endpackage

>>> design/tip_front.sv
// Front end: classifies one incoming character into a token.
// Depends on tip_pkg.
module tip_front (
  input  logic              [7:0] character,
  input  logic                    want_signed,
  output tip_pkg::tip_tok_t       tok
);

  logic is_dec;
  logic is_lo;
  logic is_up;

  always_comb begin
    is_dec = (character >= tip_pkg::CH_0) && (character <= tip_pkg::CH_9);
    is_lo  = (character >= tip_pkg::CH_LO_A) && (character <= tip_pkg::CH_LO_F);
    is_up  = (character >= tip_pkg::CH_UP_A) && (character <= tip_pkg::CH_UP_F);
    tok.is_end      = (character == tip_pkg::CH_NUL);
    tok.is_zero     = (character == tip_pkg::CH_0);
    tok.is_dec      = is_dec;
    tok.is_hex      = is_dec || is_lo || is_up;
    tok.is_minus    = (character == tip_pkg::CH_MINUS);
    tok.is_x        = (character == tip_pkg::CH_LO_X);
    // letters a-f / A-F have low nibble 1..6
    tok.digit       = is_dec ? character[3:0] : (character[3:0] + 4'd9);
    tok.want_signed = want_signed;
  end

endmodule

>>> design/tip_fifo.sv
// Token queue between front and back, first-word fall-through.
// Depends on tip_pkg and text_integer_parser_assert.svh.
`include "text_integer_parser_assert.svh"

module tip_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tip_pkg::tip_tok_t push_tok,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output tip_pkg::tip_tok_t head_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tip_pkg::tip_tok_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head_tok  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : (wr_ptr_r + PW'(1));
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : (rd_ptr_r + PW'(1));
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  `TIP_ASSERT_NOW(a_no_overflow, push, !full)
  `TIP_ASSERT_NOW(a_no_underflow, pop, not_empty)
  `TIP_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + CW'(1))

endmodule

>>> design/tip_back.sv
// Back end: parse state machine and result register.
// Depends on tip_pkg and text_integer_parser_assert.svh.
`include "text_integer_parser_assert.svh"

module tip_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_valid,
  input  tip_pkg::tip_tok_t tok,
  output logic              tok_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_value,
  output logic              out_ok
);

  tip_pkg::tip_phase_t phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        sc_r, sc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r;
  logic        out_ok_r;

  logic        slot_free;
  logic        end_pop;
  logic [31:0] acc_in;
  logic [3:0]  cnt_in;
  logic [31:0] lim;
  logic [3:0]  last;
  logic        dec_bad;
  logic [31:0] dec_acc;
  logic [31:0] res_value;
  logic        res_ok;

  assign slot_free = !out_valid_r || out_ready;
  assign tok_pop   = tok_valid && (!tok.is_end || slot_free);
  assign end_pop   = tok_pop && tok.is_end;

  // one decimal digit step; after a leading zero the zero counts as a digit
  always_comb begin
    acc_in  = (phase_r == tip_pkg::PH_ZERO) ? 32'd0 : acc_r;
    cnt_in  = (phase_r == tip_pkg::PH_ZERO) ? 4'd1  : cnt_r;
    lim     = sc_r ? tip_pkg::DEC_LIM_S : tip_pkg::DEC_LIM_U;
    last    = sc_r ? (neg_r ? tip_pkg::LAST_S_NEG : tip_pkg::LAST_S_POS) : tip_pkg::LAST_U;
    dec_bad = !tok.is_dec || (cnt_in >= tip_pkg::DEC_MAX_DIGITS) ||
              ((cnt_in == tip_pkg::DEC_LAST_POS) &&
               ((acc_in > lim) || ((acc_in == lim) && (tok.digit > last))));
    dec_acc = (acc_in << 3) + (acc_in << 1) + {28'd0, tok.digit};
  end

  always_comb begin
    res_value = 32'd0;
    res_ok    = 1'b0;
    unique case (phase_r)
      tip_pkg::PH_ZERO: res_ok = 1'b1;
      tip_pkg::PH_HEX: begin
        res_ok    = 1'b1;
        res_value = acc_r;
      end
      tip_pkg::PH_DEC: begin
        res_ok    = 1'b1;
        res_value = neg_r ? (32'd0 - acc_r) : acc_r;
      end
      default: res_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    sc_nxt        = sc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (end_pop) begin
      out_valid_nxt = 1'b1;
      phase_nxt     = tip_pkg::PH_START;
      acc_nxt       = '0;
      cnt_nxt       = '0;
      neg_nxt       = 1'b0;
      sc_nxt        = 1'b0;
    end else if (tok_pop) begin
      unique case (phase_r)
        tip_pkg::PH_START: begin
          sc_nxt = tok.want_signed;
          if (tok.is_zero) begin
            phase_nxt = tip_pkg::PH_ZERO;
          end else if (tok.is_minus) begin
            neg_nxt   = 1'b1;
            phase_nxt = tip_pkg::PH_DEC;
          end else if (tok.is_dec) begin
            phase_nxt = tip_pkg::PH_DEC;
            acc_nxt   = dec_acc;
            cnt_nxt   = 4'd1;
          end else begin
            phase_nxt = tip_pkg::PH_FAIL;
          end
        end
        tip_pkg::PH_ZERO: begin
          if (tok.is_x) begin
            phase_nxt = tip_pkg::PH_HEX_FIRST;
          end else if (dec_bad) begin
            phase_nxt = tip_pkg::PH_FAIL;
          end else begin
            phase_nxt = tip_pkg::PH_DEC;
            acc_nxt   = dec_acc;
            cnt_nxt   = cnt_in + 4'd1;
          end
        end
        tip_pkg::PH_HEX_FIRST, tip_pkg::PH_HEX: begin
          if (!tok.is_hex || (cnt_r >= tip_pkg::HEX_MAX_DIGITS)) begin
            phase_nxt = tip_pkg::PH_FAIL;
          end else begin
            phase_nxt = tip_pkg::PH_HEX;
            acc_nxt   = {acc_r[27:0], tok.digit};
            cnt_nxt   = cnt_r + 4'd1;
          end
        end
        tip_pkg::PH_DEC: begin
          if (dec_bad) begin
            phase_nxt = tip_pkg::PH_FAIL;
          end else begin
            acc_nxt = dec_acc;
            cnt_nxt = cnt_r + 4'd1;
          end
        end
        default: phase_nxt = tip_pkg::PH_FAIL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tip_pkg::PH_START;
      acc_r       <= '0;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      sc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
      sc_r        <= sc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (end_pop) begin
      out_value_r <= res_value;
      out_ok_r    <= res_ok;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_ok    = out_ok_r;

  `TIP_ASSERT_NEXT(a_end_gives_result, end_pop, out_valid_r)
  `TIP_ASSERT_NEXT(a_end_clears, end_pop, (phase_r == tip_pkg::PH_START) && (acc_r == 32'd0))
  `TIP_ASSERT_NOW(a_fail_is_zero, out_valid_r && !out_ok_r, out_value_r == 32'd0)

endmodule

>>> design/text_integer_parser.sv
// Text integer parser: ASCII characters in, one 32-bit value plus ok flag per string.
// Throughput: one character per cycle if the queue has room; out_tready low holds results.
// A zero character is queued, then sets the result register that drives out_*.
// Rate is set by the back end: one token per cycle; end tokens wait on a full result slot.
// Reset: synchronous, active low on rst_n; clears queue, parse state and result valid.
// Depends on tip_pkg, tip_front, tip_fifo, tip_back.
module text_integer_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input characters
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tuser,   // [0] want_signed
  // parse results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic        out_tuser   // [0] ok
);

  // Front: classify the character in the accept cycle, straight into the queue.
  tip_pkg::tip_tok_t front_tok;
  tip_pkg::tip_tok_t head_tok;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;
  logic              in_accept;

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && !q_full;

  tip_front u_front (
    .character   (in_tdata),
    .want_signed (in_tuser),
    .tok         (front_tok)
  );

  // Queue decouples input acceptance from result back-pressure:
  // characters keep flowing while a finished result waits on out_tready, until the queue fills.
  tip_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_tok  (front_tok),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_tok  (head_tok)
  );

  // Back: parse state machine; end-of-string tokens wait only for a free
  // result register, every other token is consumed at once.
  tip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_not_empty),
    .tok       (head_tok),
    .tok_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata),
    .out_ok    (out_tuser)
  );

endmodule
